/* rtl/lcd_text_nibble_encoder_macros.svh */
// ----------------------------------------------------------------------------
// lcd_text_nibble_encoder_macros.svh
// Assertion macros shared by the text nibble encoder; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef LCD_TEXT_NIBBLE_ENCODER_MACROS_SVH
`define LCD_TEXT_NIBBLE_ENCODER_MACROS_SVH

`ifndef SYNTH
// Check that a condition holds at every clock edge outside reset
`define LCDNIB_ASSERT(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("lcdnib assertion failed");
// Check that a condition implies another one
`define LCDNIB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcdnib implication failed");
`else
`define LCDNIB_ASSERT(label, clk, rst_n, cond)
`define LCDNIB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/lcdnib_pkg.sv */
// ----------------------------------------------------------------------------
// lcdnib_pkg
// Constants, types and the transfer formatter of the text nibble encoder.
// ----------------------------------------------------------------------------
package lcdnib_pkg;

    localparam int LINE_WIDTH_DEF = 16;
    localparam int MAX_RESULTS    = 18;
    localparam int MAX_PAD        = MAX_RESULTS - 2;
    localparam int PAD_W          = $clog2(MAX_PAD + 1);

    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

    // Port expander bits and display codes
    localparam logic [7:0] BIT_RS       = 8'h01;
    localparam logic [7:0] BIT_EN       = 8'h04;
    localparam logic [7:0] BIT_BL       = 8'h08;
    localparam logic [7:0] HI_MASK      = 8'hF0;
    localparam logic [7:0] LO_MASK      = 8'h0F;
    localparam logic [7:0] CMD_LINE2    = 8'hC0;
    localparam logic [7:0] CMD_HOME     = 8'h80;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    // One classified text item, as queued between front and back
    typedef struct packed {
        logic [7:0]       character;
        logic             is_newline;
        logic             eom;
        logic [PAD_W-1:0] pad;
    } cmd_t;

    // Four port bytes of one transfer
    typedef struct packed {
        logic [7:0] hi_strobe;
        logic [7:0] hi_latch;
        logic [7:0] lo_strobe;
        logic [7:0] lo_latch;
    } xfer_t;

    // Build the four port bytes for one code
    function automatic xfer_t make_xfer(input logic [7:0] code, input logic data,
                                        input logic bl);
        xfer_t      x;
        logic [7:0] side;
        logic [7:0] hi;
        logic [7:0] lo;
        side = (bl ? BIT_BL : 8'h00) | (data ? BIT_RS : 8'h00);
        hi   = code & HI_MASK;
        lo   = (code & LO_MASK) << 4;
        x.hi_strobe = hi | side | BIT_EN;
        x.hi_latch  = hi | side;
        x.lo_strobe = lo | side | BIT_EN;
        x.lo_latch  = lo | side;
        return x;
    endfunction

endpackage

/* rtl/lcdnib_front.sv */
// ----------------------------------------------------------------------------
// lcdnib_front
// Accepts text items, tracks the column and computes newline padding.
// ----------------------------------------------------------------------------
module lcdnib_front #(
    parameter int LINE_WIDTH = lcdnib_pkg::LINE_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic [7:0]        character,
    input  logic              end_of_message,
    input  logic              q_full,
    output logic              push,
    output lcdnib_pkg::cmd_t  push_cmd
);
    import lcdnib_pkg::*;

    localparam int COL_W = $clog2(LINE_WIDTH + 1);

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic             newline;
    logic             below_full;
    logic [COL_W:0]   room;

    // Hold off the source while the queue is full
    assign item_stall = q_full;
    assign push       = item_valid && !q_full;

    // Classify the item and size the padding
    always_comb
    begin
        newline    = (character == CHAR_NEWLINE);
        below_full = (col_reg < COL_W'(LINE_WIDTH));
        room       = below_full ? ((COL_W + 1)'(LINE_WIDTH) - {1'b0, col_reg})
                                : '0;
        push_cmd.character  = character;
        push_cmd.is_newline = newline;
        push_cmd.eom        = end_of_message;
        if (!newline)
            push_cmd.pad = '0;
        else if (room > (COL_W + 1)'(MAX_PAD))
            push_cmd.pad = PAD_W'(MAX_PAD);
        else
            push_cmd.pad = PAD_W'(room);
    end

    // Advance the column counter on each accepted beat; clear it at a newline or end of message
    always_comb
    begin
        col_next = col_reg;
        if (push)
        begin
            if (end_of_message || newline)
                col_next = '0;
            else if (below_full)
                col_next = col_reg + COL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            col_reg <= '0;
        else
            col_reg <= col_next;
    end

endmodule

/* rtl/lcdnib_queue.sv */
// ----------------------------------------------------------------------------
// lcdnib_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module lcdnib_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  lcdnib_pkg::cmd_t push_cmd,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output lcdnib_pkg::cmd_t head_cmd
);
    import lcdnib_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg;
    logic [QPTR_W-1:0] rptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W-1:0] wptr_next;
    logic [QPTR_W-1:0] rptr_next;
    logic [QPTR_W:0]   count_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = slot_reg[rptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // Advance pointers and fill count
    always_comb
    begin
        wptr_next  = do_push ? wptr_reg + QPTR_W'(1) : wptr_reg;
        rptr_next  = do_pop ? rptr_reg + QPTR_W'(1) : rptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (QPTR_W + 1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (QPTR_W + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Store the pushed beat
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wptr_reg] <= push_cmd;
    end

endmodule

/* rtl/lcdnib_back.sv */
// ----------------------------------------------------------------------------
// lcdnib_back
// Expands each queued item into display transfers through an output register.
// ----------------------------------------------------------------------------
module lcdnib_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             backlight,
    input  logic             q_empty,
    input  lcdnib_pkg::cmd_t head_cmd,
    output logic             pop,
    output logic             xfer_valid,
    input  logic             xfer_stall,
    output logic [7:0]       high_nibble_strobe,
    output logic [7:0]       high_nibble_latch,
    output logic [7:0]       low_nibble_strobe,
    output logic [7:0]       low_nibble_latch,
    output logic             is_data,
    output logic             last
);
    import lcdnib_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PAD  = 4'b0010,
        ST_MAIN = 4'b0100,
        ST_HOME = 4'b1000
    } back_state_t;

    back_state_t state_reg;
    back_state_t state_next;
    cmd_t        cmd_reg;
    cmd_t        cmd_next;
    logic        valid_reg;
    logic        valid_next;
    xfer_t       xfer_reg;
    logic        data_reg;
    logic        last_reg;
    logic        can_load;
    logic        load;
    logic [7:0]  code;
    logic        code_data;
    logic        code_last;

    assign can_load = !valid_reg || !xfer_stall;

    // Sequence padding, main transfer and home command
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        pop        = 1'b0;
        load       = 1'b0;
        code       = CHAR_SPACE;
        code_data  = 1'b1;
        code_last  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    cmd_next   = head_cmd;
                    state_next = (head_cmd.pad != '0) ? ST_PAD : ST_MAIN;
                end
            end
            ST_PAD:
            begin
                if (can_load)
                begin
                    load         = 1'b1;
                    cmd_next.pad = cmd_reg.pad - PAD_W'(1);
                    if (cmd_reg.pad == PAD_W'(1))
                        state_next = ST_MAIN;
                end
            end
            ST_MAIN:
            begin
                if (can_load)
                begin
                    load       = 1'b1;
                    code       = cmd_reg.is_newline ? CMD_LINE2 : cmd_reg.character;
                    code_data  = !cmd_reg.is_newline;
                    code_last  = !cmd_reg.eom;
                    state_next = cmd_reg.eom ? ST_HOME : ST_IDLE;
                end
            end
            ST_HOME:
            begin
                if (can_load)
                begin
                    load       = 1'b1;
                    code       = CMD_HOME;
                    code_data  = 1'b0;
                    code_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the output beat until the sink takes it
    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (!xfer_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (load)
        begin
            xfer_reg <= make_xfer(code, code_data, backlight);
            data_reg <= code_data;
            last_reg <= code_last;
        end
    end

    assign xfer_valid         = valid_reg;
    assign high_nibble_strobe = xfer_reg.hi_strobe;
    assign high_nibble_latch  = xfer_reg.hi_latch;
    assign low_nibble_strobe  = xfer_reg.lo_strobe;
    assign low_nibble_latch   = xfer_reg.lo_latch;
    assign is_data            = data_reg;
    assign last               = last_reg;

endmodule

/* rtl/lcd_text_nibble_encoder.sv */
// ----------------------------------------------------------------------------
// lcd_text_nibble_encoder
// Text to 4-bit character display transfer encoder.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel (item_valid/item_stall): one text byte and an end-of-message
//   flag per beat. A newline pads the line with spaces to LINE_WIDTH columns
//   and sends the second-line command; end of message adds the home command.
//   Transfer channel (xfer_valid/xfer_stall): one beat per display transfer,
//   four port bytes plus is_data and last; last marks the final transfer of
//   an item. Config channel (cfg_valid/cfg_ready/cfg_data): backlight bit,
//   always ready; write it only while the block is idle.
//   An item beat is written into the queue, then popped by the back sequencer
//   into its command register; transfers leave through the output register.
//   The back takes a new item only once the last transfer of the one before
//   is loaded. An item gives 1 to 18 transfers at the default width, and a newline pads at most MAX_PAD spaces.
//   A two-entry queue lets the front keep taking items while the back works.
//   Reset clears the column counter, the queue and the output beat, and sets
//   the backlight bit. When the sink stalls, the output beat holds, the back
//   waits, and once the queue fills item_stall rises.
// ----------------------------------------------------------------------------
`include "lcd_text_nibble_encoder_macros.svh"

module lcd_text_nibble_encoder #(
    parameter int LINE_WIDTH = lcdnib_pkg::LINE_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [7:0] character,
    input  logic       end_of_message,
    output logic       xfer_valid,
    input  logic       xfer_stall,
    output logic [7:0] high_nibble_strobe,
    output logic [7:0] high_nibble_latch,
    output logic [7:0] low_nibble_strobe,
    output logic [7:0] low_nibble_latch,
    output logic       is_data,
    output logic       last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);
    import lcdnib_pkg::*;

    logic backlight_reg;
    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    cmd_t push_cmd;
    cmd_t head_cmd;

    // Backlight register, written on each config beat
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            backlight_reg <= 1'b1;
        else if (cfg_valid && cfg_ready)
            backlight_reg <= cfg_data;
    end

    lcdnib_front #(
        .LINE_WIDTH (LINE_WIDTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .character      (character),
        .end_of_message (end_of_message),
        .q_full         (q_full),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    lcdnib_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head_cmd (head_cmd)
    );

    lcdnib_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .backlight          (backlight_reg),
        .q_empty            (q_empty),
        .head_cmd           (head_cmd),
        .pop                (pop),
        .xfer_valid         (xfer_valid),
        .xfer_stall         (xfer_stall),
        .high_nibble_strobe (high_nibble_strobe),
        .high_nibble_latch  (high_nibble_latch),
        .low_nibble_strobe  (low_nibble_strobe),
        .low_nibble_latch   (low_nibble_latch),
        .is_data            (is_data),
        .last               (last)
    );

    // Strobe and latch bytes differ only in the enable bit
    `LCDNIB_ASSERT_IMPL(a_hi_enable_only, clk, rst_n, xfer_valid, (high_nibble_strobe ^ high_nibble_latch) == BIT_EN)
    `LCDNIB_ASSERT_IMPL(a_lo_enable_only, clk, rst_n, xfer_valid, (low_nibble_strobe ^ low_nibble_latch) == BIT_EN)
    // Register select follows the data flag; commands have the top bit set and a zero low nibble
    `LCDNIB_ASSERT_IMPL(a_rs_matches, clk, rst_n, xfer_valid, high_nibble_latch[0] == is_data && low_nibble_latch[0] == is_data)
    `LCDNIB_ASSERT_IMPL(a_cmd_code, clk, rst_n, xfer_valid && !is_data, high_nibble_latch[7] == 1'b1 && low_nibble_latch[7:4] == 4'h0)

endmodule
